// ----- hdl/pgwae_pkg.sv -----
// Package for the glyph width array encoder.
// Holds the item words, the token and command codes, and the control/status
// structs that join the controller and the datapath. No dependencies.
package pgwae_pkg;

  localparam logic [31:0] SCALE_MILLI = 32'd1000;
  localparam int unsigned GAP_LIMIT = 4;
  localparam int unsigned RUN_MIN = 2;
  localparam int unsigned DIV_STEPS = 32;
  localparam logic [14:0] UPEM_RESET = 15'd1000;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_FULL = 2'd1;
  localparam logic [1:0] ERR_ORDER = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_NEXT   = 2'd2
  } cmd_code_e;

  typedef enum logic [2:0] {
    TOK_DEFAULT = 3'd0,
    TOK_RUN     = 3'd1,
    TOK_OPEN    = 3'd2,
    TOK_VALUE   = 3'd3,
    TOK_CLOSE   = 3'd4,
    TOK_DONE    = 3'd5
  } tok_kind_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SCAN,
    PH_GAP,
    PH_CONT,
    PH_DONE
  } emit_phase_e;

  typedef enum logic [5:0] {
    ST_IDLE, ST_L_CLR, ST_L_CHK, ST_L_DIV, ST_L_STORE,
    ST_I_CHK, ST_I_RD, ST_I_CMP,
    ST_M_INIT, ST_M_CHK, ST_M_UPD,
    ST_S_SET, ST_S_CHK, ST_S_TST, ST_R_CHK, ST_R_TST, ST_R_DEC,
    ST_C_SET, ST_C_CHK, ST_C_TST, ST_C_N1CHK, ST_C_N1TST, ST_C_N2CHK, ST_C_N2TST,
    ST_C_GO, ST_G_CHK, ST_G_RD, ST_G_TAKE,
    ST_O_DEF, ST_O_RUN, ST_O_OPEN, ST_O_ZERO, ST_O_VAL, ST_O_CLOSE, ST_O_DONE
  } ctl_state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] glyph_id;
    logic [21:0] advance_font_units;
  } pgwae_in_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] glyph_first;
    logic [15:0] glyph_last;
    logic [31:0] advance_value;
    logic [1:0]  status;
  } pgwae_out_t;

  typedef struct packed {
    logic      take_item;
    logic      clear_table;
    logic      latch_full;
    logic      latch_order;
    logic      div_start;
    logic      div_step;
    logic      store_entry;
    logic      k_init;
    logic      idx_km1;
    logic      ins_shift;
    logic      ins_put;
    logic      mode_init;
    logic      mode_step;
    logic      mode_done;
    logic      idx_from_cur;
    logic      idx_inc;
    logic      cur_from_idx;
    logic      cur_from_base;
    logic      cur_inc;
    logic      base_take;
    logic      glast_take;
    logic      cont_take;
    logic      val_take;
    logic      gap_zero;
    logic      gap_from_dc;
    logic      gap_dec;
    logic      emit;
    logic      emit_zero;
    tok_kind_e kind;
  } pgwae_cmd_t;

  typedef struct packed {
    logic full;
    logic not_asc;
    logic div_done;
    logic frac_zero;
    logic k_zero;
    logic s_gt;
    logic idx_end;
    logic midx_end;
    logic cur_end;
    logic a_def;
    logic a_eq;
    logic run2;
    logic gap_nz;
    logic dc_ge4;
    logic sum_ge4;
    logic out_free;
  } pgwae_sts_t;

endpackage

// ----- hdl/pgwae_ram.sv -----
// Generic single write, single read RAM with registered read data.
// No dependencies.
module pgwae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/pgwae_dp.sv -----
// Datapath of the glyph width array encoder: stores, divider, mode walk,
// emission registers and the output word register.
// Depends on pgwae_pkg and pgwae_ram.
module pgwae_dp import pgwae_pkg::*; #(
  parameter int MAX_GLYPHS = 1024,
  parameter int ADVANCE_FRACTION_BITS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pgwae_in_t  in_word_i,
  input  logic       cfg_valid_i,
  input  logic [14:0] cfg_data_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output pgwae_out_t out_word_o,
  input  pgwae_cmd_t cmd_i,
  output pgwae_sts_t sts_o
);

  localparam int AW = $clog2(MAX_GLYPHS);
  localparam int CW = $clog2(MAX_GLYPHS + 1);
  localparam logic [31:0] FRAC_MASK = (32'd1 << ADVANCE_FRACTION_BITS) - 32'd1;

  logic [14:0]   upem_q;
  logic [15:0]   item_gid_q;
  logic [21:0]   item_adv_q;
  logic [CW-1:0] ec_q, ic_q, cur_q, k_q, idx_q, base_q, cnt_q, mcnt_q;
  logic [15:0]   last_gid_q, gap_q;
  logic [1:0]    err_q;
  logic [31:0]   default_q;
  logic [14:0]   rem_q;
  logic [31:0]   quo_q;
  logic [5:0]    dcnt_q;
  logic [31:0]   ai_q, mcur_q, mode_q;
  logic [15:0]   gi_q, glast_q, prev_q, gj_q, dc_q;
  pgwae_out_t    out_q;
  logic          out_valid_q;

  logic [31:0] a_rdata, s_rdata;
  logic [15:0] g_rdata;
  logic [14:0] divisor;
  logic [15:0] trial;
  logic        ge;
  logic [15:0] dc_now, ndc;
  logic        s_we;
  logic [31:0] s_wdata;
  pgwae_out_t  out_d;

  assign divisor = (upem_q == 15'd0) ? 15'd1 : upem_q;
  assign trial   = {rem_q, quo_q[31]};
  assign ge      = trial >= {1'b0, divisor};
  assign dc_now  = g_rdata - prev_q - 16'd1;
  assign ndc     = g_rdata - gj_q - 16'd1;

  pgwae_ram #(.WIDTH(16), .DEPTH(MAX_GLYPHS)) u_glyph_ram (
    .clk_i,
    .we_i    (cmd_i.store_entry),
    .waddr_i (ec_q[AW-1:0]),
    .wdata_i (item_gid_q),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (g_rdata)
  );

  pgwae_ram #(.WIDTH(32), .DEPTH(MAX_GLYPHS)) u_adv_ram (
    .clk_i,
    .we_i    (cmd_i.store_entry),
    .waddr_i (ec_q[AW-1:0]),
    .wdata_i (quo_q),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (a_rdata)
  );

  assign s_we    = cmd_i.ins_shift | cmd_i.ins_put;
  assign s_wdata = cmd_i.ins_shift ? s_rdata : quo_q;

  pgwae_ram #(.WIDTH(32), .DEPTH(MAX_GLYPHS)) u_sort_ram (
    .clk_i,
    .we_i    (s_we),
    .waddr_i (k_q[AW-1:0]),
    .wdata_i (s_wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (s_rdata)
  );

  always_comb begin
    sts_o.full      = ec_q == CW'(MAX_GLYPHS);
    sts_o.not_asc   = (ec_q != '0) && (item_gid_q <= last_gid_q);
    sts_o.div_done  = dcnt_q == 6'd0;
    sts_o.frac_zero = (quo_q & FRAC_MASK) == 32'd0;
    sts_o.k_zero    = k_q == '0;
    sts_o.s_gt      = s_rdata > quo_q;
    sts_o.idx_end   = idx_q >= ec_q;
    sts_o.midx_end  = idx_q >= ic_q;
    sts_o.cur_end   = cur_q >= ec_q;
    sts_o.a_def     = (a_rdata >> ADVANCE_FRACTION_BITS) ==
                      (default_q >> ADVANCE_FRACTION_BITS);
    sts_o.a_eq      = a_rdata == ai_q;
    sts_o.run2      = (idx_q - base_q) >= CW'(RUN_MIN);
    sts_o.gap_nz    = gap_q != 16'd0;
    sts_o.dc_ge4    = dc_now >= 16'(GAP_LIMIT);
    sts_o.sum_ge4   = ({1'b0, dc_q} + {1'b0, ndc}) >= 17'(GAP_LIMIT);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    out_d.token_kind    = cmd_i.kind;
    out_d.glyph_first   = 16'd0;
    out_d.glyph_last    = 16'd0;
    out_d.advance_value = 32'd0;
    out_d.status        = err_q;
    unique case (cmd_i.kind)
      TOK_DEFAULT: out_d.advance_value = default_q;
      TOK_RUN: begin
        out_d.glyph_first   = gi_q;
        out_d.glyph_last    = glast_q;
        out_d.advance_value = ai_q;
      end
      TOK_OPEN:  out_d.glyph_first = gi_q;
      TOK_VALUE: out_d.advance_value = cmd_i.emit_zero ? 32'd0 : ai_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upem_q      <= UPEM_RESET;
      ec_q        <= '0;
      ic_q        <= '0;
      cur_q       <= '0;
      gap_q       <= 16'd0;
      err_q       <= ERR_NONE;
      default_q   <= 32'd0;
      dcnt_q      <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        upem_q <= cfg_data_i;
      end
      if (cmd_i.clear_table) begin
        ec_q  <= '0;
        ic_q  <= '0;
        err_q <= ERR_NONE;
        cur_q <= '0;
        gap_q <= 16'd0;
      end
      if (cmd_i.latch_full && err_q == ERR_NONE) begin
        err_q <= ERR_FULL;
      end
      if (cmd_i.latch_order && err_q == ERR_NONE) begin
        err_q <= ERR_ORDER;
      end
      if (cmd_i.div_start) begin
        dcnt_q <= 6'(DIV_STEPS);
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q - 6'd1;
      end
      if (cmd_i.store_entry) begin
        ec_q <= ec_q + CW'(1);
      end
      if (cmd_i.ins_put) begin
        ic_q <= ic_q + CW'(1);
      end
      if (cmd_i.mode_done) begin
        default_q <= (cnt_q > mcnt_q) ? mcur_q : mode_q;
        cur_q     <= '0;
        gap_q     <= 16'd0;
      end
      if (cmd_i.cur_from_idx) begin
        cur_q <= idx_q;
      end else if (cmd_i.cur_from_base) begin
        cur_q <= base_q;
      end else if (cmd_i.cur_inc) begin
        cur_q <= cur_q + CW'(1);
      end
      if (cmd_i.gap_zero) begin
        gap_q <= 16'd0;
      end else if (cmd_i.gap_from_dc) begin
        gap_q <= dc_q;
      end else if (cmd_i.gap_dec) begin
        gap_q <= gap_q - 16'd1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      item_gid_q <= in_word_i.glyph_id;
      item_adv_q <= in_word_i.advance_font_units;
    end
    if (cmd_i.div_start) begin
      rem_q <= 15'd0;
      quo_q <= 32'(item_adv_q) * SCALE_MILLI;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? 15'(trial - {1'b0, divisor}) : trial[14:0];
      quo_q <= {quo_q[30:0], ge};
    end
    if (cmd_i.store_entry) begin
      last_gid_q <= item_gid_q;
    end
    if (cmd_i.k_init) begin
      k_q <= ic_q;
    end else if (cmd_i.ins_shift) begin
      k_q <= k_q - CW'(1);
    end
    if (cmd_i.idx_km1) begin
      idx_q <= k_q - CW'(1);
    end else if (cmd_i.mode_init) begin
      idx_q <= '0;
    end else if (cmd_i.idx_from_cur) begin
      idx_q <= cur_q;
    end else if (cmd_i.idx_inc || cmd_i.mode_step) begin
      idx_q <= idx_q + CW'(1);
    end
    if (cmd_i.mode_init) begin
      cnt_q  <= '0;
      mcnt_q <= '0;
      mode_q <= 32'd0;
    end else if (cmd_i.mode_step) begin
      if (cnt_q != '0 && s_rdata == mcur_q) begin
        cnt_q <= cnt_q + CW'(1);
      end else begin
        if (cnt_q > mcnt_q) begin
          mode_q <= mcur_q;
          mcnt_q <= cnt_q;
        end
        mcur_q <= s_rdata;
        cnt_q  <= CW'(1);
      end
    end
    if (cmd_i.base_take) begin
      base_q  <= idx_q;
      ai_q    <= a_rdata;
      gi_q    <= g_rdata;
      glast_q <= g_rdata;
    end
    if (cmd_i.glast_take) begin
      glast_q <= g_rdata;
    end
    if (cmd_i.cont_take) begin
      dc_q <= dc_now;
      gj_q <= g_rdata;
      ai_q <= a_rdata;
    end
    if (cmd_i.val_take) begin
      ai_q   <= a_rdata;
      prev_q <= g_rdata;
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- hdl/pgwae_ctrl.sv -----
// Controller of the glyph width array encoder: sequences loads, the mode
// walk and token emission, and holds the emission phase.
// Depends on pgwae_pkg.
module pgwae_ctrl import pgwae_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_cmd_i,
  output logic       in_ready_o,
  input  pgwae_sts_t sts_i,
  output pgwae_cmd_t cmd_o
);

  ctl_state_e  state_q, state_d;
  emit_phase_e phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_IDLE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_cmd_i)
            CMD_LOAD:   state_d = (phase_q != PH_IDLE) ? ST_L_CLR : ST_L_CHK;
            CMD_FINISH: state_d = ST_M_INIT;
            CMD_NEXT: begin
              unique case (phase_q)
                PH_SCAN: state_d = ST_S_SET;
                PH_GAP:  state_d = ST_G_CHK;
                PH_CONT: state_d = ST_C_SET;
                PH_DONE: state_d = ST_O_DONE;
                default: state_d = ST_IDLE;
              endcase
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_L_CLR: begin
        phase_d = PH_IDLE;
        state_d = ST_L_CHK;
      end
      ST_L_CHK:   state_d = (sts_i.full || sts_i.not_asc) ? ST_IDLE : ST_L_DIV;
      ST_L_DIV:   state_d = sts_i.div_done ? ST_L_STORE : ST_L_DIV;
      ST_L_STORE: state_d = sts_i.frac_zero ? ST_I_CHK : ST_IDLE;
      ST_I_CHK:   state_d = sts_i.k_zero ? ST_IDLE : ST_I_RD;
      ST_I_RD:    state_d = ST_I_CMP;
      ST_I_CMP:   state_d = sts_i.s_gt ? ST_I_CHK : ST_IDLE;
      ST_M_INIT:  state_d = ST_M_CHK;
      ST_M_CHK: begin
        if (sts_i.midx_end) begin
          phase_d = PH_SCAN;
          state_d = ST_O_DEF;
        end else begin
          state_d = ST_M_UPD;
        end
      end
      ST_M_UPD: state_d = ST_M_CHK;
      ST_S_SET: state_d = ST_S_CHK;
      ST_S_CHK: begin
        if (sts_i.idx_end) begin
          phase_d = PH_DONE;
          state_d = ST_O_DONE;
        end else begin
          state_d = ST_S_TST;
        end
      end
      ST_S_TST: state_d = sts_i.a_def ? ST_S_CHK : ST_R_CHK;
      ST_R_CHK: state_d = sts_i.idx_end ? ST_R_DEC : ST_R_TST;
      ST_R_TST: state_d = sts_i.a_eq ? ST_R_CHK : ST_R_DEC;
      ST_R_DEC: begin
        if (sts_i.run2) begin
          state_d = ST_O_RUN;
        end else begin
          phase_d = PH_GAP;
          state_d = ST_O_OPEN;
        end
      end
      ST_C_SET: state_d = ST_C_CHK;
      ST_C_CHK: begin
        if (sts_i.idx_end) begin
          phase_d = PH_SCAN;
          state_d = ST_O_CLOSE;
        end else begin
          state_d = ST_C_TST;
        end
      end
      ST_C_TST: begin
        if (sts_i.a_def || sts_i.dc_ge4) begin
          phase_d = PH_SCAN;
          state_d = ST_O_CLOSE;
        end else begin
          state_d = ST_C_N1CHK;
        end
      end
      ST_C_N1CHK: state_d = sts_i.idx_end ? ST_C_GO : ST_C_N1TST;
      ST_C_N1TST: begin
        if (!sts_i.a_eq) begin
          state_d = ST_C_GO;
        end else if (sts_i.sum_ge4) begin
          phase_d = PH_SCAN;
          state_d = ST_O_CLOSE;
        end else begin
          state_d = ST_C_N2CHK;
        end
      end
      ST_C_N2CHK: state_d = sts_i.idx_end ? ST_C_GO : ST_C_N2TST;
      ST_C_N2TST: begin
        if (sts_i.a_eq) begin
          phase_d = PH_SCAN;
          state_d = ST_O_CLOSE;
        end else begin
          state_d = ST_C_GO;
        end
      end
      ST_C_GO: begin
        phase_d = PH_GAP;
        state_d = ST_G_CHK;
      end
      ST_G_CHK: begin
        if (sts_i.gap_nz) begin
          state_d = ST_O_ZERO;
        end else if (sts_i.cur_end) begin
          phase_d = PH_SCAN;
          state_d = ST_O_CLOSE;
        end else begin
          state_d = ST_G_RD;
        end
      end
      ST_G_RD: state_d = ST_G_TAKE;
      ST_G_TAKE: begin
        phase_d = PH_CONT;
        state_d = ST_O_VAL;
      end
      ST_O_DONE: begin
        phase_d = PH_DONE;
        state_d = sts_i.out_free ? ST_IDLE : ST_O_DONE;
      end
      ST_O_DEF, ST_O_RUN, ST_O_OPEN, ST_O_ZERO, ST_O_VAL, ST_O_CLOSE: begin
        state_d = sts_i.out_free ? ST_IDLE : state_q;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = TOK_DONE;
    in_ready_o = state_q == ST_IDLE;
    unique case (state_q)
      ST_IDLE:  cmd_o.take_item = in_valid_i;
      ST_L_CLR: cmd_o.clear_table = 1'b1;
      ST_L_CHK: begin
        cmd_o.latch_full  = sts_i.full;
        cmd_o.latch_order = !sts_i.full && sts_i.not_asc;
        cmd_o.div_start   = !sts_i.full && !sts_i.not_asc;
      end
      ST_L_DIV: cmd_o.div_step = !sts_i.div_done;
      ST_L_STORE: begin
        cmd_o.store_entry = 1'b1;
        cmd_o.k_init      = 1'b1;
      end
      ST_I_CHK: begin
        cmd_o.ins_put = sts_i.k_zero;
        cmd_o.idx_km1 = !sts_i.k_zero;
      end
      ST_I_CMP: begin
        cmd_o.ins_shift = sts_i.s_gt;
        cmd_o.ins_put   = !sts_i.s_gt;
      end
      ST_M_INIT: cmd_o.mode_init = 1'b1;
      ST_M_CHK:  cmd_o.mode_done = sts_i.midx_end;
      ST_M_UPD:  cmd_o.mode_step = 1'b1;
      ST_S_SET:  cmd_o.idx_from_cur = 1'b1;
      ST_S_CHK:  cmd_o.cur_from_idx = sts_i.idx_end;
      ST_S_TST: begin
        cmd_o.idx_inc   = 1'b1;
        cmd_o.base_take = !sts_i.a_def;
      end
      ST_R_TST: begin
        cmd_o.glast_take = sts_i.a_eq;
        cmd_o.idx_inc    = sts_i.a_eq;
      end
      ST_R_DEC: begin
        cmd_o.cur_from_idx  = sts_i.run2;
        cmd_o.cur_from_base = !sts_i.run2;
        cmd_o.gap_zero      = !sts_i.run2;
      end
      ST_C_SET: cmd_o.idx_from_cur = 1'b1;
      ST_C_TST: begin
        cmd_o.cont_take = !(sts_i.a_def || sts_i.dc_ge4);
        cmd_o.idx_inc   = !(sts_i.a_def || sts_i.dc_ge4);
      end
      ST_C_N1TST: cmd_o.idx_inc = sts_i.a_eq && !sts_i.sum_ge4;
      ST_C_GO:    cmd_o.gap_from_dc = 1'b1;
      ST_G_CHK: begin
        cmd_o.gap_dec      = sts_i.gap_nz;
        cmd_o.idx_from_cur = !sts_i.gap_nz && !sts_i.cur_end;
      end
      ST_G_TAKE: begin
        cmd_o.val_take = 1'b1;
        cmd_o.cur_inc  = 1'b1;
      end
      ST_O_DEF: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.kind = TOK_DEFAULT;
      end
      ST_O_RUN: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.kind = TOK_RUN;
      end
      ST_O_OPEN: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.kind = TOK_OPEN;
      end
      ST_O_ZERO: begin
        cmd_o.emit      = sts_i.out_free;
        cmd_o.kind      = TOK_VALUE;
        cmd_o.emit_zero = 1'b1;
      end
      ST_O_VAL: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.kind = TOK_VALUE;
      end
      ST_O_CLOSE: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.kind = TOK_CLOSE;
      end
      ST_O_DONE: begin
        cmd_o.emit = sts_i.out_free;
        cmd_o.kind = TOK_DONE;
      end
      default: ;
    endcase
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("token emitted while output word still held");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_step |-> !sts_i.div_done)
    else $error("divider stepped past its last bit");

  a_store_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.store_entry |-> (!sts_i.full && !sts_i.not_asc))
    else $error("entry stored into full store or out of order");

  a_item_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.take_item && (in_cmd_i == CMD_LOAD || in_cmd_i == CMD_FINISH)) |=> !in_ready_o)
    else $error("accepted word did not start its sequence");

endmodule

// ----- hdl/pdf_glyph_width_array_encoder_top.sv -----
// Glyph width array encoder, top level. A load runs a serial divide by
// units_per_em and, for a whole-number advance, an insertion into the sorted
// store that shifts each larger entry. A finish walks the whole-number advances;
// a next token walks the store entries that it visits.
// One word at a time; reset is asynchronous, active low, units_per_em=1000.
module pdf_glyph_width_array_encoder_top import pgwae_pkg::*; #(
  parameter int MAX_GLYPHS = 1024,
  parameter int ADVANCE_FRACTION_BITS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pgwae_in_t   in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pgwae_out_t  out_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i
);

  pgwae_cmd_t cmd;
  pgwae_sts_t sts;

  assign cfg_ready_o = 1'b1;

  pgwae_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_cmd_i   (in_word_i.command),
    .in_ready_o,
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pgwae_dp #(
    .MAX_GLYPHS            (MAX_GLYPHS),
    .ADVANCE_FRACTION_BITS (ADVANCE_FRACTION_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .in_word_i,
    .cfg_valid_i,
    .cfg_data_i,
    .out_ready_i,
    .out_valid_o,
    .out_word_o,
    .cmd_i (cmd),
    .sts_o (sts)
  );

endmodule

// ----- bench/pdf_glyph_width_array_encoder_top_tb.sv -----
// Self-checking bench for pdf_glyph_width_array_encoder_top: predicts every
// token of the glyph width array and compares it with the block's output words.
// Depends on pgwae_pkg and the top-level RTL only.
module pdf_glyph_width_array_encoder_top_tb;
  import pgwae_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NGLYPH = 1024;
  localparam int FRAC = 6;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int IDLE_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 3400;

  class width_array_scoreboard;
    logic [14:0] upem;
    logic [15:0] gid_mem[NGLYPH];
    logic [31:0] adv_mem[NGLYPH];
    logic [31:0] whole_sorted[NGLYPH];
    int unsigned n_entries, n_whole, cursor, gap_left;
    logic [31:0] dflt;
    logic [1:0] err;
    emit_phase_e phase;
    pgwae_out_t token_q[$];
    int errors;

    function new();
      upem = UPEM_RESET;
      dflt = 0;
      errors = 0;
      clear();
    endfunction

    function void clear();
      n_entries = 0;
      n_whole = 0;
      err = ERR_NONE;
      cursor = 0;
      gap_left = 0;
      phase = PH_IDLE;
    endfunction

    function void push(tok_kind_e k, logic [15:0] f, logic [15:0] l, logic [31:0] v);
      pgwae_out_t t;
      t.token_kind = k;
      t.glyph_first = f;
      t.glyph_last = l;
      t.advance_value = v;
      t.status = err;
      token_q = {token_q, t};
    endfunction

    function void latch_err(logic [1:0] code);
      if (err == ERR_NONE) err = code;
    endfunction

    function void store_glyph(logic [15:0] gid, logic [21:0] adv);
      longint unsigned div;
      logic [31:0] v;
      int unsigned p;
      div = (upem == 0) ? 1 : upem;
      if (n_entries >= NGLYPH) begin
        latch_err(ERR_FULL);
        return;
      end
      if (n_entries > 0 && gid <= gid_mem[n_entries-1]) begin
        latch_err(ERR_ORDER);
        return;
      end
      v = 32'((longint'(adv) * SCALE_MILLI) / div);
      gid_mem[n_entries] = gid;
      adv_mem[n_entries] = v;
      n_entries++;
      if (v[FRAC-1:0] == 0) begin
        p = 0;
        while (p < n_whole && whole_sorted[p] <= v) p++;
        for (int i = n_whole; i > p; i--) whole_sorted[i] = whole_sorted[i-1];
        whole_sorted[p] = v;
        n_whole++;
      end
    endfunction

    function logic [31:0] mode_width();
      logic [31:0] cur, best;
      int unsigned cnt, bcnt;
      if (n_whole == 0) return 0;
      cur = whole_sorted[0];
      best = cur;
      cnt = 1;
      bcnt = 1;
      for (int i = 1; i < n_whole; i++) begin
        if (whole_sorted[i] == cur) cnt++;
        else begin
          if (cnt > bcnt) begin
            best = cur;
            bcnt = cnt;
          end
          cur = whole_sorted[i];
          cnt = 1;
        end
      end
      return (cnt > bcnt) ? cur : best;
    endfunction

    function bit is_dflt(logic [31:0] v);
      return (v >> FRAC) == (dflt >> FRAC);
    endfunction

    function bit range_stops(int unsigned j);
      logic [31:0] a;
      int unsigned dc, ndc;
      if (j >= n_entries) return 1;
      a = adv_mem[j];
      if (is_dflt(a)) return 1;
      dc = gid_mem[j] - gid_mem[j-1] - 1;
      if (dc >= GAP_LIMIT) return 1;
      if (j + 1 < n_entries && adv_mem[j+1] == a) begin
        ndc = gid_mem[j+1] - gid_mem[j] - 1;
        if (dc + ndc >= GAP_LIMIT) return 1;
        if (j + 2 < n_entries && adv_mem[j+2] == a) return 1;
      end
      return 0;
    endfunction

    function void gap_or_value();
      logic [31:0] v;
      if (gap_left > 0) begin
        gap_left--;
        push(TOK_VALUE, 0, 0, 0);
      end else if (cursor >= n_entries) begin
        phase = PH_SCAN;
        push(TOK_CLOSE, 0, 0, 0);
      end else begin
        v = adv_mem[cursor];
        cursor++;
        phase = PH_CONT;
        push(TOK_VALUE, 0, 0, v);
      end
    endfunction

    function void next_token();
      int unsigned i, j;
      case (phase)
        PH_SCAN: begin
          i = cursor;
          while (i < n_entries && is_dflt(adv_mem[i])) i++;
          if (i >= n_entries) begin
            cursor = i;
            phase = PH_DONE;
            push(TOK_DONE, 0, 0, 0);
          end else begin
            j = i + 1;
            while (j < n_entries && adv_mem[j] == adv_mem[i]) j++;
            if (j - i >= RUN_MIN) begin
              cursor = j;
              push(TOK_RUN, gid_mem[i], gid_mem[j-1], adv_mem[i]);
            end else begin
              cursor = i;
              gap_left = 0;
              phase = PH_GAP;
              push(TOK_OPEN, gid_mem[i], 0, 0);
            end
          end
        end
        PH_CONT: begin
          if (range_stops(cursor)) begin
            phase = PH_SCAN;
            push(TOK_CLOSE, 0, 0, 0);
          end else begin
            gap_left = gid_mem[cursor] - gid_mem[cursor-1] - 1;
            phase = PH_GAP;
            gap_or_value();
          end
        end
        PH_GAP: gap_or_value();
        default: begin
          phase = PH_DONE;
          push(TOK_DONE, 0, 0, 0);
        end
      endcase
    endfunction

    function void note_word(pgwae_in_t w);
      case (w.command)
        CMD_LOAD: begin
          if (phase != PH_IDLE) clear();
          store_glyph(w.glyph_id, w.advance_font_units);
        end
        CMD_FINISH: begin
          dflt = mode_width();
          cursor = 0;
          gap_left = 0;
          phase = PH_SCAN;
          push(TOK_DEFAULT, 0, 0, dflt);
        end
        CMD_NEXT: if (phase != PH_IDLE) next_token();
        default: ;
      endcase
    endfunction

    function void check_word(pgwae_out_t got);
      pgwae_out_t exp_w;
      if (token_q.size() == 0) begin
        $error("unexpected token kind=%0d", got.token_kind);
        errors++;
        return;
      end
      exp_w = token_q.pop_front();
      if (got.token_kind !== exp_w.token_kind) begin
        $error("token_kind exp %0d got %0d", exp_w.token_kind, got.token_kind);
        errors++;
      end
      if (got.glyph_first !== exp_w.glyph_first) begin
        $error("glyph_first exp %0d got %0d", exp_w.glyph_first, got.glyph_first);
        errors++;
      end
      if (got.glyph_last !== exp_w.glyph_last) begin
        $error("glyph_last exp %0d got %0d", exp_w.glyph_last, got.glyph_last);
        errors++;
      end
      if (got.advance_value !== exp_w.advance_value) begin
        $error("advance_value exp %0h got %0h", exp_w.advance_value, got.advance_value);
        errors++;
      end
      if (got.status !== exp_w.status) begin
        $error("status exp %0d got %0d", exp_w.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  pgwae_in_t in_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  pgwae_out_t out_word_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [14:0] cfg_data_i = '0;

  width_array_scoreboard sb = new();
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int n_words = 0;
  int quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  pdf_glyph_width_array_encoder_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_word_o(out_word_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_word(out_word_o);
      out_ready_i <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic drive_word(logic [1:0] cmd, logic [15:0] gid, logic [21:0] adv);
    pgwae_in_t w;
    w.command = cmd;
    w.glyph_id = gid;
    w.advance_font_units = adv;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
    n_words++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.token_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_upem(logic [14:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.upem = val;
  endtask

  task automatic emit_all();
    drive_word(CMD_FINISH, 16'($urandom), 22'($urandom));
    while (sb.phase != PH_DONE) begin
      if ($urandom_range(99) < 2) drive_word(CMD_FINISH, 0, 0);
      drive_word(CMD_NEXT, 16'($urandom), 22'($urandom));
    end
    if ($urandom_range(99) < 30) drive_word(CMD_NEXT, 0, 0);
  endtask

  task automatic random_table(logic [14:0] upem);
    int n;
    int unsigned gid;
    logic [21:0] pool[3];
    logic [21:0] adv;
    n = ($urandom_range(99) < 8) ? $urandom_range(200, 25) : $urandom_range(24, 2);
    gid = $urandom_range(65535 - n * 6);
    for (int k = 0; k < 3; k++) pool[k] = 22'($urandom_range(4, 1) * 8 * upem);
    adv = pool[0];
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0, 1: ;
        2: adv = 22'($urandom);
        default: adv = pool[$urandom_range(2)];
      endcase
      if ($urandom_range(99) < 4 && gid > 0)
        drive_word(CMD_LOAD, 16'(gid - $urandom_range(1)), adv);
      else if ($urandom_range(99) < 3)
        drive_word(($urandom_range(1)) ? CMD_NEXT : CMD_NONE, 16'($urandom), 22'($urandom));
      else
        drive_word(CMD_LOAD, 16'(gid), adv);
      gid += ($urandom_range(3) == 0) ? $urandom_range(6, 2) : 1;
    end
    if ($urandom_range(99) < 90) emit_all();
  endtask

  initial begin
    logic [14:0] upem_set[6];
    upem_set = '{15'd1000, 15'd16, 15'd16384, 15'd0, 15'd777, 15'd3000};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_word(CMD_NEXT, 0, 0);
    drive_word(CMD_NONE, 16'hffff, 22'h3fffff);
    drive_word(CMD_LOAD, 0, 22'd640);
    drive_word(CMD_LOAD, 1, 22'd640);
    drive_word(CMD_LOAD, 2, 22'd640);
    drive_word(CMD_LOAD, 3, 22'd6400);
    drive_word(CMD_LOAD, 5, 22'd448);
    drive_word(CMD_LOAD, 6, 22'd448);
    drive_word(CMD_LOAD, 7, 22'd100);
    drive_word(CMD_LOAD, 9, 22'd101);
    drive_word(CMD_LOAD, 9, 22'd5);
    drive_word(CMD_LOAD, 20, 22'd101);
    drive_word(CMD_LOAD, 65535, 22'h3fffff);
    emit_all();
    drive_word(CMD_FINISH, 0, 0);
    drive_word(CMD_NEXT, 0, 0);
    drive_word(CMD_NEXT, 0, 0);

    for (int p = 0; p < 6; p++) begin
      write_upem(upem_set[p]);
      case (p % 4)
        0: begin in_idle_pct = 0; out_stall_pct = 0; end
        1: begin in_idle_pct = 83; out_stall_pct = 0; end
        2: begin in_idle_pct = 0; out_stall_pct = 83; end
        default: begin in_idle_pct = 18; out_stall_pct = 18; end
      endcase
      while (n_words < 16 + (p + 1) * 60) random_table(upem_set[p]);
    end

    write_upem(15'd1000);
    in_idle_pct = 0;
    out_stall_pct = 0;
    for (int k = 0; k <= NGLYPH; k++) drive_word(CMD_LOAD, 16'(k * 2), 22'd1);
    drive_word(CMD_FINISH, 0, 0);
    repeat (4) drive_word(CMD_NEXT, 0, 0);
    drive_word(CMD_LOAD, 16'd7, 22'd64);
    emit_all();

    drain();
    if (sb.errors == 0 && sb.token_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
